>>> hdl/bmfhp_pkg.sv
// Shared types and constants for the bitmap-font header parser.
// Used by bmfhp_parse, bmfhp_chars and the core top level.
package bmfhp_pkg;

    localparam logic [3:0] ST_OK             = 4'd0;
    localparam logic [3:0] ST_INVALID_SIZE   = 4'd1;
    localparam logic [3:0] ST_BAD_HEADER     = 4'd2;
    localparam logic [3:0] ST_NO_INFO        = 4'd3;
    localparam logic [3:0] ST_NO_COMMON      = 4'd4;
    localparam logic [3:0] ST_MULTIPAGE      = 4'd5;
    localparam logic [3:0] ST_NO_PAGES       = 4'd6;
    localparam logic [3:0] ST_NO_CHARS       = 4'd7;
    localparam logic [3:0] ST_BAD_CHARS_SIZE = 4'd8;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    localparam logic [7:0] MAGIC_0   = 8'h42;
    localparam logic [7:0] MAGIC_1   = 8'h4D;
    localparam logic [7:0] MAGIC_2   = 8'h46;
    localparam logic [7:0] VERSION_3 = 8'd3;
    localparam logic [7:0] VERSION_4 = 8'd4;

    localparam logic [7:0] BLOCK_INFO   = 8'd1;
    localparam logic [7:0] BLOCK_COMMON = 8'd2;
    localparam logic [7:0] BLOCK_PAGES  = 8'd3;
    localparam logic [7:0] BLOCK_CHARS  = 8'd4;

    localparam int MIN_LENGTH     = 9;
    localparam int BLOCK_HDR_ROOM = 5;
    localparam int COMMON_MIN     = 10;

    // x / 5 == (x * RECIP_5) >> RECIP_SHIFT for any x below 2^32
    localparam logic [31:0] RECIP_5     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 34;

    typedef struct packed {
        logic [3:0]  status;
        logic        chars_check;
        logic        over;
        logic [31:0] size;
        logic [15:0] height;
        logic [15:0] ascent;
        logic [23:0] offs;
    } bmfhp_res_t;

endpackage

>>> hdl/bmfhp_parse.sv
// Input register and header-parsing state machine of the bitmap-font parser.
// Depends on bmfhp_pkg; feeds bmfhp_chars with at most one result request per parse.
module bmfhp_parse #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_kind,
    input  logic [23:0]             s_buffer_length,
    input  logic [7:0]              s_data_byte,
    output logic                    res_valid,
    input  logic                    res_ready,
    output bmfhp_pkg::bmfhp_res_t   res_data
);
    import bmfhp_pkg::*;

    typedef enum logic [14:0] {
        PH_IDLE  = 15'b000000000000001,
        PH_MAGIC = 15'b000000000000010,
        PH_T1    = 15'b000000000000100,
        PH_S1    = 15'b000000000001000,
        PH_K1    = 15'b000000000010000,
        PH_T2    = 15'b000000000100000,
        PH_S2    = 15'b000000001000000,
        PH_D2    = 15'b000000010000000,
        PH_K2    = 15'b000000100000000,
        PH_T3    = 15'b000001000000000,
        PH_S3    = 15'b000010000000000,
        PH_K3    = 15'b000100000000000,
        PH_T4    = 15'b001000000000000,
        PH_S4    = 15'b010000000000000,
        PH_DONE  = 15'b100000000000000
    } phase_t;

    logic                   in_valid_reg;
    logic                   kind_reg;
    logic [23:0]            len_reg;
    logic [7:0]             byte_reg;

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] off_reg, off_next;
    logic [LENGTH_BITS-1:0] total_reg, total_next;
    logic [31:0]            acc_reg, acc_next;
    logic [31:0]            skip_reg, skip_next;
    logic [15:0]            height_reg, height_next;
    logic [15:0]            ascent_reg, ascent_next;
    logic [3:0]             idx_reg, idx_next;

    logic                   res_valid_reg;
    bmfhp_res_t             res_reg, res_next;

    logic                   consume;
    logic                   produce;
    logic [31:0]            len32;
    logic [LENGTH_BITS-1:0] len_trunc;
    logic [LENGTH_BITS-1:0] off_inc;
    logic [LENGTH_BITS-1:0] rem;
    logic [31:0]            rem32;
    logic [31:0]            acc_or;
    logic [31:0]            skip_dec;
    logic [31:0]            offs32;
    logic [3:0]             idx_inc;
    logic                   over;
    logic                   no_room;
    logic                   magic_good;

    assign consume   = in_valid_reg && (!res_valid_reg || res_ready);
    assign s_ready   = !in_valid_reg || consume;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    assign len32     = 32'(len_reg);
    assign len_trunc = len32[LENGTH_BITS-1:0];
    assign off_inc   = off_reg + LENGTH_BITS'(1);
    assign rem       = (off_inc > total_reg) ? '0 : total_reg - off_inc;
    assign rem32     = 32'(rem);
    assign acc_or    = acc_reg | (32'(byte_reg) << {idx_reg[1:0], 3'b000});
    assign idx_inc   = idx_reg + 4'd1;
    assign over      = acc_or > rem32;
    assign no_room   = rem32 < 32'(BLOCK_HDR_ROOM);
    assign skip_dec  = (skip_reg != 32'd0) ? skip_reg - 32'd1 : 32'd0;
    assign offs32    = 32'(off_inc) - 32'd4;

    always_comb begin
        case (idx_reg)
            4'd0:    magic_good = (byte_reg == MAGIC_0);
            4'd1:    magic_good = (byte_reg == MAGIC_1);
            4'd2:    magic_good = (byte_reg == MAGIC_2);
            default: magic_good = (byte_reg == VERSION_3) || (byte_reg == VERSION_4);
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        off_next    = off_reg;
        total_next  = total_reg;
        acc_next    = acc_reg;
        skip_next   = skip_reg;
        height_next = height_reg;
        ascent_next = ascent_reg;
        idx_next    = idx_reg;
        produce     = 1'b0;

        res_next             = res_reg;
        res_next.status      = ST_OK;
        res_next.chars_check = 1'b0;
        res_next.over        = over;
        res_next.size        = acc_or;
        res_next.height      = height_reg;
        res_next.ascent      = ascent_reg;
        res_next.offs        = offs32[23:0];

        if (consume) begin
            if (kind_reg == KIND_START) begin
                phase_next  = PH_MAGIC;
                off_next    = '0;
                total_next  = len_trunc;
                acc_next    = '0;
                skip_next   = '0;
                height_next = '0;
                ascent_next = '0;
                idx_next    = '0;
                if (len_trunc < LENGTH_BITS'(MIN_LENGTH)) begin
                    produce         = 1'b1;
                    res_next.status = ST_INVALID_SIZE;
                    phase_next      = PH_DONE;
                end
            end else if (phase_reg != PH_IDLE && phase_reg != PH_DONE) begin
                off_next = off_inc;
                unique case (phase_reg)
                    PH_MAGIC: begin
                        if (!magic_good) begin
                            produce         = 1'b1;
                            res_next.status = ST_BAD_HEADER;
                            phase_next      = PH_DONE;
                        end else if (idx_reg >= 4'd3) begin
                            phase_next = PH_T1;
                        end else begin
                            idx_next = idx_inc;
                        end
                    end
                    PH_T1: begin
                        if (byte_reg != BLOCK_INFO) begin
                            produce         = 1'b1;
                            res_next.status = ST_NO_INFO;
                            phase_next      = PH_DONE;
                        end else begin
                            acc_next   = '0;
                            idx_next   = '0;
                            phase_next = PH_S1;
                        end
                    end
                    PH_T2: begin
                        if (byte_reg != BLOCK_COMMON) begin
                            produce         = 1'b1;
                            res_next.status = ST_NO_COMMON;
                            phase_next      = PH_DONE;
                        end else begin
                            acc_next   = '0;
                            idx_next   = '0;
                            phase_next = PH_S2;
                        end
                    end
                    PH_T3: begin
                        if (byte_reg != BLOCK_PAGES) begin
                            produce         = 1'b1;
                            res_next.status = ST_NO_PAGES;
                            phase_next      = PH_DONE;
                        end else begin
                            acc_next   = '0;
                            idx_next   = '0;
                            phase_next = PH_S3;
                        end
                    end
                    PH_T4: begin
                        if (byte_reg != BLOCK_CHARS) begin
                            produce         = 1'b1;
                            res_next.status = ST_NO_CHARS;
                            phase_next      = PH_DONE;
                        end else begin
                            acc_next   = '0;
                            idx_next   = '0;
                            phase_next = PH_S4;
                        end
                    end
                    PH_S1: begin
                        acc_next = acc_or;
                        idx_next = idx_inc;
                        if (idx_inc == 4'd4) begin
                            if (over) begin
                                produce         = 1'b1;
                                res_next.status = ST_INVALID_SIZE;
                                phase_next      = PH_DONE;
                            end else if (acc_or == 32'd0) begin
                                if (no_room) begin
                                    produce         = 1'b1;
                                    res_next.status = ST_NO_COMMON;
                                    phase_next      = PH_DONE;
                                end else begin
                                    phase_next = PH_T2;
                                end
                            end else begin
                                skip_next  = acc_or;
                                phase_next = PH_K1;
                            end
                        end
                    end
                    PH_S2: begin
                        acc_next = acc_or;
                        idx_next = idx_inc;
                        if (idx_inc == 4'd4) begin
                            if (rem32 < 32'(COMMON_MIN) || acc_or < 32'(COMMON_MIN) || over)
                            begin
                                produce         = 1'b1;
                                res_next.status = ST_INVALID_SIZE;
                                phase_next      = PH_DONE;
                            end else begin
                                skip_next  = acc_or - 32'(COMMON_MIN);
                                acc_next   = '0;
                                idx_next   = '0;
                                phase_next = PH_D2;
                            end
                        end
                    end
                    PH_S3: begin
                        acc_next = acc_or;
                        idx_next = idx_inc;
                        if (idx_inc == 4'd4) begin
                            if (over) begin
                                produce         = 1'b1;
                                res_next.status = ST_INVALID_SIZE;
                                phase_next      = PH_DONE;
                            end else if (acc_or == 32'd0) begin
                                if (no_room) begin
                                    produce         = 1'b1;
                                    res_next.status = ST_NO_CHARS;
                                    phase_next      = PH_DONE;
                                end else begin
                                    phase_next = PH_T4;
                                end
                            end else begin
                                skip_next  = acc_or;
                                phase_next = PH_K3;
                            end
                        end
                    end
                    PH_S4: begin
                        acc_next = acc_or;
                        idx_next = idx_inc;
                        if (idx_inc == 4'd4) begin
                            produce              = 1'b1;
                            res_next.chars_check = 1'b1;
                            phase_next           = PH_DONE;
                        end
                    end
                    PH_D2: begin
                        if (idx_reg >= 4'd9) begin
                            if ((acc_reg | {16'd0, byte_reg, 8'd0}) != 32'd1) begin
                                produce         = 1'b1;
                                res_next.status = ST_MULTIPAGE;
                                phase_next      = PH_DONE;
                            end else if (skip_reg == 32'd0) begin
                                if (no_room) begin
                                    produce         = 1'b1;
                                    res_next.status = ST_NO_PAGES;
                                    phase_next      = PH_DONE;
                                end else begin
                                    phase_next = PH_T3;
                                end
                            end else begin
                                phase_next = PH_K2;
                            end
                        end else begin
                            case (idx_reg)
                                4'd0:    height_next = {8'd0, byte_reg};
                                4'd1:    height_next = height_reg | {byte_reg, 8'd0};
                                4'd2:    ascent_next = {8'd0, byte_reg};
                                4'd3:    ascent_next = ascent_reg | {byte_reg, 8'd0};
                                4'd8:    acc_next    = 32'(byte_reg);
                                default: acc_next    = acc_reg;
                            endcase
                            idx_next = idx_inc;
                        end
                    end
                    PH_K1: begin
                        skip_next = skip_dec;
                        if (skip_dec == 32'd0) begin
                            if (no_room) begin
                                produce         = 1'b1;
                                res_next.status = ST_NO_COMMON;
                                phase_next      = PH_DONE;
                            end else begin
                                phase_next = PH_T2;
                            end
                        end
                    end
                    PH_K2: begin
                        skip_next = skip_dec;
                        if (skip_dec == 32'd0) begin
                            if (no_room) begin
                                produce         = 1'b1;
                                res_next.status = ST_NO_PAGES;
                                phase_next      = PH_DONE;
                            end else begin
                                phase_next = PH_T3;
                            end
                        end
                    end
                    PH_K3: begin
                        skip_next = skip_dec;
                        if (skip_dec == 32'd0) begin
                            if (no_room) begin
                                produce         = 1'b1;
                                res_next.status = ST_NO_CHARS;
                                phase_next      = PH_DONE;
                            end else begin
                                phase_next = PH_T4;
                            end
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= s_kind;
            len_reg  <= s_buffer_length;
            byte_reg <= s_data_byte;
        end
        if (!res_valid_reg || res_ready) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            off_reg       <= '0;
            total_reg     <= '0;
            acc_reg       <= '0;
            skip_reg      <= '0;
            height_reg    <= '0;
            ascent_reg    <= '0;
            idx_reg       <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (!res_valid_reg || res_ready) begin
                res_valid_reg <= consume && produce;
            end
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            total_reg  <= total_next;
            acc_reg    <= acc_next;
            skip_reg   <= skip_next;
            height_reg <= height_next;
            ascent_reg <= ascent_next;
            idx_reg    <= idx_next;
        end
    end

`ifndef ASSERT_OFF
    a_result_ends_parse: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && produce |=> phase_reg == PH_DONE)
        else $error("parse result did not end the parse");

    a_idle_byte_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && kind_reg == KIND_BYTE && (phase_reg == PH_IDLE || phase_reg == PH_DONE)
        |-> !produce)
        else $error("byte outside a parse produced a result");
`endif

endmodule

>>> hdl/bmfhp_chars.sv
// Chars-block size check and divide-by-20 stage, plus the result register.
// Depends on bmfhp_pkg; takes result requests from bmfhp_parse.
module bmfhp_chars (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    res_valid,
    output logic                    res_ready,
    input  bmfhp_pkg::bmfhp_res_t   res_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [3:0]              m_status,
    output logic [15:0]             m_line_height,
    output logic [15:0]             m_ascent,
    output logic [23:0]             m_chars_offset,
    output logic [19:0]             m_char_count
);
    import bmfhp_pkg::*;

    logic        v2_reg;
    logic [3:0]  st2_reg;
    logic        chk2_reg;
    logic        over2_reg;
    logic [1:0]  low2_reg;
    logic [29:0] x2_reg;
    logic [27:0] q2_reg;
    logic [15:0] h2_reg;
    logic [15:0] a2_reg;
    logic [23:0] offs2_reg;

    logic        out_valid_reg;
    logic [3:0]  status_reg;
    logic [15:0] height_reg;
    logic [15:0] ascent_reg;
    logic [23:0] offs_reg;
    logic [19:0] count_reg;

    logic        out_ready;
    logic [61:0] prod;
    logic [29:0] r5;
    logic        ok;

    assign out_ready = !out_valid_reg || m_ready;
    assign res_ready = !v2_reg || out_ready;

    assign prod = 62'(res_data.size[31:2]) * 62'(RECIP_5);
    assign r5   = x2_reg - ({q2_reg, 2'b00} + 30'(q2_reg));
    assign ok   = chk2_reg && (r5 == 30'd0) && (low2_reg == 2'b00) && !over2_reg;

    always_ff @(posedge aclk) begin
        if (res_ready) begin
            st2_reg   <= res_data.status;
            chk2_reg  <= res_data.chars_check;
            over2_reg <= res_data.over;
            low2_reg  <= res_data.size[1:0];
            x2_reg    <= res_data.size[31:2];
            q2_reg    <= prod[61:RECIP_SHIFT];
            h2_reg    <= res_data.height;
            a2_reg    <= res_data.ascent;
            offs2_reg <= res_data.offs;
        end
        if (out_ready) begin
            status_reg <= chk2_reg ? (ok ? ST_OK : ST_BAD_CHARS_SIZE) : st2_reg;
            height_reg <= ok ? h2_reg : '0;
            ascent_reg <= ok ? a2_reg : '0;
            offs_reg   <= ok ? offs2_reg : '0;
            count_reg  <= ok ? q2_reg[19:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (res_ready) begin
                v2_reg <= res_valid;
            end
            if (out_ready) begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_line_height  = height_reg;
    assign m_ascent       = ascent_reg;
    assign m_chars_offset = offs_reg;
    assign m_char_count   = count_reg;

`ifndef ASSERT_OFF
    a_quotient_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> r5 < 30'd5)
        else $error("divide-by-5 quotient out of range");

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_line_height == 16'd0 && m_ascent == 16'd0
            && m_chars_offset == 24'd0 && m_char_count == 20'd0)
        else $error("error result carries nonzero fields");
`endif

endmodule

>>> hdl/bitmap_font_header_parser_core.sv
// Bitmap-font header parser: takes one request per clock while not stalled (a start request
// with the buffer length, then one file byte per request) and returns at most one result per
// buffer, at the first header error or once the chars block size is read. Bytes stream with
// no gaps while the output does not stall; the request that settles a result passes through
// the input register, the parse register, then the divide-by-20 multiplier stage and the
// result register. A pending result does not stop new requests until the three result
// stages and the input register are all full.
// LENGTH_BITS sets the internal length/offset width.
module bitmap_font_header_parser_core #(
    parameter int LENGTH_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [23:0] s_buffer_length,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [15:0] m_line_height,
    output logic [15:0] m_ascent,
    output logic [23:0] m_chars_offset,
    output logic [19:0] m_char_count
);
    import bmfhp_pkg::*;

    logic       res_valid;
    logic       res_ready;
    bmfhp_res_t res_data;

    bmfhp_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_buffer_length (s_buffer_length),
        .s_data_byte     (s_data_byte),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res_data        (res_data)
    );

    bmfhp_chars u_chars (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_data       (res_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_line_height  (m_line_height),
        .m_ascent       (m_ascent),
        .m_chars_offset (m_chars_offset),
        .m_char_count   (m_char_count)
    );

endmodule

>>> verif/bitmap_font_header_parser_core_tb.sv
// Self-checking testbench for bitmap_font_header_parser_core: drives font buffers byte by
// byte and checks every result against an in-bench header parser.
// Depends on bmfhp_pkg and the core RTL only.
`timescale 1ns / 1ps

module bitmap_font_header_parser_core_tb;
    import bmfhp_pkg::*;

    localparam int CHAR_RECORD_BYTES = 20;
    localparam int CYCLE_LIMIT       = 500000;
    localparam int HOLD_OFF_CYCLES   = 300;

    typedef enum logic [4:0] {
        PARSE_IDLE, PARSE_MAGIC,
        INFO_TYPE, INFO_SIZE, INFO_SKIP,
        COMMON_TYPE, COMMON_SIZE, COMMON_DATA, COMMON_SKIP,
        PAGES_TYPE, PAGES_SIZE, PAGES_SKIP,
        CHARS_TYPE, CHARS_SIZE, PARSE_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] line_height;
        logic [15:0] ascent;
        logic [23:0] chars_offset;
        logic [19:0] char_count;
    } font_result_t;

    class header_scoreboard;
        font_result_t expected_results[$];
        int           failures;
        int           results_predicted;
        parse_phase_t phase;
        logic [23:0]  offset;
        logic [23:0]  total;
        logic [31:0]  size_acc;
        logic [31:0]  skip_left;
        logic [15:0]  height;
        logic [15:0]  ascent;
        logic [3:0]   field;

        function new();
            failures = 0;
            results_predicted = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase = PARSE_IDLE;
            offset = '0;
            total = '0;
            size_acc = '0;
            skip_left = '0;
            height = '0;
            ascent = '0;
            field = '0;
        endfunction

        function logic [31:0] remaining();
            return (offset > total) ? 32'd0 : 32'(total - offset);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void push_result(logic [3:0] status, logic [31:0] offs, logic [31:0] count);
            font_result_t r;
            r = '0;
            r.status = status;
            if (status == ST_OK) begin
                r.line_height  = height;
                r.ascent       = ascent;
                r.chars_offset = offs[23:0];
                r.char_count   = count[19:0];
            end
            expected_results.push_back(r);
            results_predicted++;
            phase = PARSE_DONE;
        endfunction

        function void enter_type(parse_phase_t type_phase, logic [3:0] err);
            if (remaining() < BLOCK_HDR_ROOM) push_result(err, 0, 0);
            else phase = type_phase;
        endfunction

        function void enter_skip(logic [31:0] n, parse_phase_t skip_phase,
                                 parse_phase_t type_phase, logic [3:0] err);
            if (n == 0) begin
                enter_type(type_phase, err);
            end else begin
                skip_left = n;
                phase = skip_phase;
            end
        endfunction

        function void enter_size(parse_phase_t size_phase, logic [7:0] b, logic [7:0] want,
                                 logic [3:0] err);
            if (b != want) begin
                push_result(err, 0, 0);
            end else begin
                size_acc = '0;
                field = '0;
                phase = size_phase;
            end
        endfunction

        function void note_request(logic kind, logic [23:0] len, logic [7:0] b);
            logic [31:0] rem;
            logic [3:0]  idx;
            logic        good;
            if (kind == KIND_START) begin
                clear_parse();
                total = len;
                if (total < MIN_LENGTH) push_result(ST_INVALID_SIZE, 0, 0);
                else phase = PARSE_MAGIC;
                return;
            end
            if (phase == PARSE_IDLE || phase == PARSE_DONE) return;
            offset = offset + 24'd1;
            rem = remaining();
            idx = field;
            case (phase)
                PARSE_MAGIC: begin
                    case (idx)
                        4'd0:    good = (b == MAGIC_0);
                        4'd1:    good = (b == MAGIC_1);
                        4'd2:    good = (b == MAGIC_2);
                        default: good = (b == VERSION_3 || b == VERSION_4);
                    endcase
                    if (!good) push_result(ST_BAD_HEADER, 0, 0);
                    else if (idx >= 3) phase = INFO_TYPE;
                    else field = idx + 4'd1;
                end
                INFO_TYPE:   enter_size(INFO_SIZE, b, BLOCK_INFO, ST_NO_INFO);
                COMMON_TYPE: enter_size(COMMON_SIZE, b, BLOCK_COMMON, ST_NO_COMMON);
                PAGES_TYPE:  enter_size(PAGES_SIZE, b, BLOCK_PAGES, ST_NO_PAGES);
                CHARS_TYPE:  enter_size(CHARS_SIZE, b, BLOCK_CHARS, ST_NO_CHARS);
                INFO_SIZE, COMMON_SIZE, PAGES_SIZE, CHARS_SIZE: begin
                    size_acc = size_acc | (32'(b) << (8 * idx[1:0]));
                    field = idx + 4'd1;
                    if (field == 4) begin
                        case (phase)
                            INFO_SIZE: begin
                                if (size_acc > rem) push_result(ST_INVALID_SIZE, 0, 0);
                                else enter_skip(size_acc, INFO_SKIP, COMMON_TYPE, ST_NO_COMMON);
                            end
                            COMMON_SIZE: begin
                                if (rem < COMMON_MIN || size_acc < COMMON_MIN || size_acc > rem) begin
                                    push_result(ST_INVALID_SIZE, 0, 0);
                                end else begin
                                    skip_left = size_acc - COMMON_MIN;
                                    size_acc = '0;
                                    field = '0;
                                    phase = COMMON_DATA;
                                end
                            end
                            PAGES_SIZE: begin
                                if (size_acc > rem) push_result(ST_INVALID_SIZE, 0, 0);
                                else enter_skip(size_acc, PAGES_SKIP, CHARS_TYPE, ST_NO_CHARS);
                            end
                            default: begin
                                if ((size_acc % CHAR_RECORD_BYTES) != 0 || size_acc > rem)
                                    push_result(ST_BAD_CHARS_SIZE, 0, 0);
                                else
                                    push_result(ST_OK, 32'(offset) - 32'd4,
                                                size_acc / CHAR_RECORD_BYTES);
                            end
                        endcase
                    end
                end
                COMMON_DATA: begin
                    if (idx >= 9) begin
                        if ((size_acc | (32'(b) << 8)) != 32'd1)
                            push_result(ST_MULTIPAGE, 0, 0);
                        else
                            enter_skip(skip_left, COMMON_SKIP, PAGES_TYPE, ST_NO_PAGES);
                    end else begin
                        case (idx)
                            4'd0: height = {8'd0, b};
                            4'd1: height[15:8] = b;
                            4'd2: ascent = {8'd0, b};
                            4'd3: ascent[15:8] = b;
                            4'd8: size_acc = 32'(b);
                            default: ;
                        endcase
                        field = idx + 4'd1;
                    end
                end
                INFO_SKIP, COMMON_SKIP, PAGES_SKIP: begin
                    if (skip_left > 0) skip_left = skip_left - 1;
                    if (skip_left == 0) begin
                        case (phase)
                            INFO_SKIP:   enter_type(COMMON_TYPE, ST_NO_COMMON);
                            COMMON_SKIP: enter_type(PAGES_TYPE, ST_NO_PAGES);
                            default:     enter_type(CHARS_TYPE, ST_NO_CHARS);
                        endcase
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(font_result_t got);
            font_result_t exp;
            if (expected_results.size() == 0) begin
                $error("result with none expected: status %0d", got.status);
                failures++;
                return;
            end
            exp = expected_results.pop_front();
            if (got.status != exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                failures++;
            end
            if (got.line_height != exp.line_height) begin
                $error("line_height: expected %0d, actual %0d", exp.line_height, got.line_height);
                failures++;
            end
            if (got.ascent != exp.ascent) begin
                $error("ascent: expected %0d, actual %0d", exp.ascent, got.ascent);
                failures++;
            end
            if (got.chars_offset != exp.chars_offset) begin
                $error("chars_offset: expected %0d, actual %0d", exp.chars_offset,
                       got.chars_offset);
                failures++;
            end
            if (got.char_count != exp.char_count) begin
                $error("char_count: expected %0d, actual %0d", exp.char_count, got.char_count);
                failures++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = KIND_START;
    logic [23:0] s_buffer_length = '0;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_status;
    logic [15:0] m_line_height;
    logic [15:0] m_ascent;
    logic [23:0] m_chars_offset;
    logic [19:0] m_char_count;

    header_scoreboard font_sb;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    logic        hold_off_request = 1'b0;
    logic [7:0]  font_bytes[$];
    logic [23:0] font_length;

    bitmap_font_header_parser_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_buffer_length (s_buffer_length),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_line_height   (m_line_height),
        .m_ascent        (m_ascent),
        .m_chars_offset  (m_chars_offset),
        .m_char_count    (m_char_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            font_sb.check_result({m_status, m_line_height, m_ascent, m_chars_offset,
                                  m_char_count});
        if (hold_off_request) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_request <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(logic kind, logic [23:0] len, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_buffer_length <= len;
        s_data_byte     <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        font_sb.note_request(kind, len, b);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (font_sb.pending() != 0);
    endtask

    function automatic void push_word(logic [31:0] w);
        for (int i = 0; i < 4; i++) font_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void push_random(int n);
        repeat (n) font_bytes.push_back(8'($urandom));
    endfunction

    function automatic void build_font();
        int          flaw;
        int          info_size;
        int          common_size;
        int          common_decl;
        int          pages_size;
        int          chars_count;
        int          type_pos[4];
        logic [31:0] chars_decl;
        logic [31:0] natural_len;
        logic [15:0] page_count;
        flaw        = $urandom_range(0, 19);
        info_size   = $urandom_range(0, 4);
        common_size = COMMON_MIN + $urandom_range(0, 3);
        common_decl = (flaw == 1) ? $urandom_range(0, COMMON_MIN - 1) : common_size;
        pages_size  = $urandom_range(0, 4);
        chars_count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 838860)
                                                  : $urandom_range(0, 3);
        chars_decl  = CHAR_RECORD_BYTES * chars_count + ((flaw == 2) ? $urandom_range(1, 19) : 0);
        page_count  = (flaw == 3) ? 16'($urandom) : 16'd1;

        font_bytes.delete();
        font_bytes.push_back(MAGIC_0);
        font_bytes.push_back(MAGIC_1);
        font_bytes.push_back(MAGIC_2);
        font_bytes.push_back($urandom_range(0, 1) ? VERSION_3 : VERSION_4);
        type_pos[0] = font_bytes.size();
        font_bytes.push_back(BLOCK_INFO);
        push_word(info_size);
        push_random(info_size);
        type_pos[1] = font_bytes.size();
        font_bytes.push_back(BLOCK_COMMON);
        push_word(common_decl);
        push_random(8);
        font_bytes.push_back(page_count[7:0]);
        font_bytes.push_back(page_count[15:8]);
        push_random(common_size - COMMON_MIN);
        type_pos[2] = font_bytes.size();
        font_bytes.push_back(BLOCK_PAGES);
        push_word(pages_size);
        push_random(pages_size);
        type_pos[3] = font_bytes.size();
        font_bytes.push_back(BLOCK_CHARS);
        push_word(chars_decl);

        natural_len = font_bytes.size() + CHAR_RECORD_BYTES * chars_count + $urandom_range(0, 3);
        font_length = (natural_len > 32'hFF_FFFF) ? 24'hFF_FFFF : natural_len[23:0];
        case (flaw)
            4: font_bytes[$urandom_range(0, font_bytes.size() - 1)] = 8'($urandom);
            5: font_length = 24'($urandom_range(0, natural_len));
            6: font_length = 24'($urandom);
            7: font_bytes = font_bytes[0:$urandom_range(0, font_bytes.size() - 2)];
            8: font_bytes[type_pos[$urandom_range(0, 3)]] = 8'($urandom);
            9: font_bytes[$urandom_range(0, 3)] = 8'($urandom);
            default: ;
        endcase
        push_random($urandom_range(0, 2));
    endfunction

    task automatic send_font();
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_request(KIND_BYTE, 24'($urandom), 8'($urandom));
        build_font();
        send_request(KIND_START, font_length, 8'($urandom));
        foreach (font_bytes[i]) send_request(KIND_BYTE, 24'($urandom), font_bytes[i]);
    endtask

    initial begin
        font_sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 67;
        send_request(KIND_BYTE, 24'hFF_FFFF, 8'hFF);
        send_request(KIND_START, 24'd0, 8'h00);
        send_request(KIND_START, 24'(MIN_LENGTH - 1), 8'hFF);
        send_request(KIND_START, 24'hFF_FFFF, 8'h00);
        send_request(KIND_BYTE, 24'd0, MAGIC_0);
        send_request(KIND_BYTE, 24'd0, MAGIC_1);
        send_request(KIND_BYTE, 24'd0, 8'h00);
        send_request(KIND_START, 24'(MIN_LENGTH), 8'h00);
        send_request(KIND_BYTE, 24'd0, MAGIC_0);
        send_request(KIND_BYTE, 24'd0, MAGIC_1);
        send_request(KIND_BYTE, 24'd0, MAGIC_2);
        send_request(KIND_BYTE, 24'd0, VERSION_4);
        send_request(KIND_BYTE, 24'd0, BLOCK_INFO);
        repeat (4) send_request(KIND_BYTE, 24'd0, 8'h00);
        send_request(KIND_BYTE, 24'd0, 8'hAA);
        send_request(KIND_START, 24'd20, 8'h00);
        send_request(KIND_BYTE, 24'd0, MAGIC_0);
        send_request(KIND_START, 24'(MIN_LENGTH), 8'h00);
        send_request(KIND_BYTE, 24'd0, MAGIC_0);
        send_request(KIND_BYTE, 24'd0, MAGIC_1);
        send_request(KIND_BYTE, 24'd0, MAGIC_2);
        send_request(KIND_BYTE, 24'd0, VERSION_4 + 8'd1);
        wait_drained();

        for (int pass_idx = 0; pass_idx < 3; pass_idx++) begin
            case (pass_idx)
                0: begin send_idle_pct = 33; recv_idle_pct = 67; end
                1: begin send_idle_pct = 67; recv_idle_pct = 33; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (pass_idx == 2) begin
                hold_off_request <= 1'b1;
                repeat (30) send_request(KIND_START, 24'($urandom_range(0, MIN_LENGTH - 1)),
                                         8'($urandom));
                wait_drained();
            end
            while (items_sent < 220 * (pass_idx + 1))
                send_font();
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (font_sb.failures == 0 && font_sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/bmfhp_pkg.sv
hdl/bmfhp_parse.sv
hdl/bmfhp_chars.sv
hdl/bitmap_font_header_parser_core.sv
verif/bitmap_font_header_parser_core_tb.sv
